// ----- src/lik_pkg.sv -----
// lik_pkg: shared widths, internal angle constants, csr indexes and the cordic arctangent table
// for the leg inverse kinematics mover. depends on nothing.
`timescale 1ns / 1ps

package lik_pkg;

   localparam int CoordW   = 16;
   localparam int LenW     = 14;
   localparam int AngW     = 14;
   localparam int TimeW    = 24;
   localparam int PhaseW   = 28;
   localparam int CordW    = 52;
   localparam int CordIdxW = 5;

   localparam logic signed [PhaseW-1:0] Deg90  = 28'sd5898240;
   localparam logic signed [PhaseW-1:0] Deg180 = 28'sd11796480;
   localparam logic [AngW-1:0] AngMax = 14'd11520;

   localparam logic [1:0] CSR_HIP_OFFSET = 2'd0;
   localparam logic [1:0] CSR_FEMUR      = 2'd1;
   localparam logic [1:0] CSR_TIBIA      = 2'd2;
   localparam logic [1:0] CSR_STEP_LIFT  = 2'd3;

   typedef logic [AngW-1:0] angle_type;

   typedef struct packed {
      logic done;
      logic ok;
   } lik_stat_type;

   // atan(2^-i) in units of 2^-16 degree
   function automatic logic signed [PhaseW-1:0] atan_step(input logic [CordIdxW-1:0] idx);
      logic signed [PhaseW-1:0] v;
      case (idx)
         5'd0:    v = 28'sd2949120;
         5'd1:    v = 28'sd1740967;
         5'd2:    v = 28'sd919879;
         5'd3:    v = 28'sd466945;
         5'd4:    v = 28'sd234379;
         5'd5:    v = 28'sd117304;
         5'd6:    v = 28'sd58666;
         5'd7:    v = 28'sd29335;
         5'd8:    v = 28'sd14668;
         5'd9:    v = 28'sd7334;
         5'd10:   v = 28'sd3667;
         5'd11:   v = 28'sd1833;
         5'd12:   v = 28'sd917;
         5'd13:   v = 28'sd458;
         5'd14:   v = 28'sd229;
         5'd15:   v = 28'sd115;
         5'd16:   v = 28'sd57;
         5'd17:   v = 28'sd29;
         5'd18:   v = 28'sd14;
         5'd19:   v = 28'sd7;
         5'd20:   v = 28'sd4;
         5'd21:   v = 28'sd2;
         5'd22:   v = 28'sd1;
         default: v = 28'sd0;
      endcase
      return v;
   endfunction

endpackage

// ----- src/lik_req_if.sv -----
// lik_req_if: request channel (foot target and duration) with valid/ready handshake.
// depends on lik_pkg.
`timescale 1ns / 1ps

interface lik_req_if import lik_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              req_type;
   logic [CoordW-1:0] target_x;
   logic [CoordW-1:0] target_y;
   logic [CoordW-1:0] target_z;
   logic [TimeW-1:0]  move_time;

   modport source (output valid, req_type, target_x, target_y, target_z, move_time,
                   input ready);
   modport sink   (input valid, req_type, target_x, target_y, target_z, move_time,
                   output ready);
endinterface

// ----- src/lik_rsp_if.sv -----
// lik_rsp_if: result channel (one linear joint move) with valid/ready handshake.
// depends on lik_pkg.
`timescale 1ns / 1ps

interface lik_rsp_if import lik_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [AngW-1:0]  start_angle_base;
   logic [AngW-1:0]  start_angle_mid;
   logic [AngW-1:0]  start_angle_tip;
   logic [AngW-1:0]  end_angle_base;
   logic [AngW-1:0]  end_angle_mid;
   logic [AngW-1:0]  end_angle_tip;
   logic [TimeW-1:0] move_span;
   logic             last_of_run;
   logic             fault;

   modport source (output valid, start_angle_base, start_angle_mid, start_angle_tip,
                   end_angle_base, end_angle_mid, end_angle_tip, move_span, last_of_run,
                   fault, input ready);
   modport sink   (input valid, start_angle_base, start_angle_mid, start_angle_tip,
                   end_angle_base, end_angle_mid, end_angle_tip, move_span, last_of_run,
                   fault, output ready);
endinterface

// ----- src/lik_engine.sv -----
// lik_engine: inverse kinematics solver for one foot position, built from a bit-serial
// multiplier, a bit-serial square root and an iterative cordic under a sequencer. uses lik_pkg.
`timescale 1ns / 1ps

module lik_engine import lik_pkg::*; #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [CoordW-1:0] x_in,
   input  logic signed [CoordW-1:0] y_in,
   input  logic signed [CoordW-1:0] z_in,
   input  logic [LenW-1:0]          hip_len,
   input  logic [LenW-1:0]          femur_len,
   input  logic [LenW-1:0]          tibia_len,
   output lik_stat_type             stat,
   output angle_type                ang_base,
   output angle_type                ang_mid,
   output angle_type                ang_tip
);

   localparam logic [4:0] E_IDLE = 5'd0;
   localparam logic [4:0] E_SQX  = 5'd1;
   localparam logic [4:0] E_SQY  = 5'd2;
   localparam logic [4:0] E_RT   = 5'd3;
   localparam logic [4:0] E_SQV  = 5'd4;
   localparam logic [4:0] E_SQZ  = 5'd5;
   localparam logic [4:0] E_SQD  = 5'd6;
   localparam logic [4:0] E_FF   = 5'd7;
   localparam logic [4:0] E_TT   = 5'd8;
   localparam logic [4:0] E_D1   = 5'd9;
   localparam logic [4:0] E_ACHK = 5'd10;
   localparam logic [4:0] E_ASHF = 5'd11;
   localparam logic [4:0] E_ADD  = 5'd12;
   localparam logic [4:0] E_AMM  = 5'd13;
   localparam logic [4:0] E_ASQ  = 5'd14;
   localparam logic [4:0] E_ACOR = 5'd15;
   localparam logic [4:0] E_D2   = 5'd16;
   localparam logic [4:0] E_BASE = 5'd17;
   localparam logic [4:0] E_MID  = 5'd18;
   localparam logic [4:0] E_FIN  = 5'd19;

   function automatic logic [17:0] mag18(input logic signed [17:0] v);
      return v[17] ? 18'(-v) : 18'(v);
   endfunction

   logic [4:0] st_ff, st_nxt;
   logic       ph_ff;
   logic       cap;
   logic       unit_busy;
   lik_stat_type stat_ff;

   logic signed [CoordW-1:0] ex_ff, ey_ff, ez_ff;
   logic [63:0]        t0_ff;
   logic signed [17:0] vv_ff;
   logic [33:0]        dsum_ff;
   logic [24:0]        ss_ff;
   logic [27:0]        fsq_ff, tsq_ff;
   logic [43:0]        ac_m_ff, ac_d_ff;
   logic               ac_neg_ff, ac_sel_ff, fail_ff;
   logic signed [PhaseW-1:0] sh_ff, kn_ff, ab_ff, az_ff;
   angle_type          ab_out_ff, am_out_ff, at_out_ff;

   // bit-serial multiplier
   logic [63:0] mul_a_ff, mul_acc_ff;
   logic [31:0] mul_b_ff;
   logic        mul_busy_ff;
   logic        mul_go;
   logic [63:0] mul_opa;
   logic [31:0] mul_opb;

   // bit-serial square root, one result bit per cycle
   logic [63:0] sq_v_ff, sq_r_ff, sq_b_ff;
   logic        sq_busy_ff;
   logic        sq_go;
   logic [63:0] sq_opv;
   logic [63:0] sq_trial;

   // vectoring cordic, one micro-rotation per cycle
   logic signed [CordW-1:0]  cor_x_ff, cor_y_ff;
   logic signed [PhaseW-1:0] cor_ang_ff;
   logic [CordIdxW-1:0]      cor_i_ff;
   logic                     cor_busy_ff;
   logic                     cor_go;
   logic signed [32:0]       cor_opx, cor_opy;
   logic signed [CordW-1:0]  cor_x0, cor_y0;

   logic signed [17:0] rt_w, vv_in;
   logic signed [44:0] n1_in, n2_in;
   logic [43:0]        n1_mag, n2_mag;
   logic               ac_bad;
   logic signed [PhaseW-1:0] fa0, fa1, fa2, q0, q1, q2;
   logic               fin_ok;

   assign unit_busy = mul_busy_ff | sq_busy_ff | cor_busy_ff;
   assign cap       = ph_ff && !unit_busy;
   assign sq_trial  = sq_r_ff + sq_b_ff;

   always_comb begin
      rt_w  = ex_ff[15] ? -$signed({2'b00, sq_r_ff[15:0]}) : $signed({2'b00, sq_r_ff[15:0]});
      vv_in = rt_w - $signed({4'b0000, hip_len});
      n1_in = ($signed(45'(fsq_ff)) - $signed(45'(tsq_ff)) + $signed(45'(dsum_ff))) <<< 8;
      n2_in = $signed(45'(fsq_ff)) + $signed(45'(tsq_ff)) - $signed(45'(dsum_ff));
      n1_mag = n1_in[44] ? 44'(-n1_in) : n1_in[43:0];
      n2_mag = n2_in[44] ? 44'(-n2_in) : n2_in[43:0];
      ac_bad = (ac_d_ff == '0) || (ac_m_ff > ac_d_ff);
      fa0 = ab_ff;
      fa1 = Deg90 - (az_ff + sh_ff);
      fa2 = Deg180 - kn_ff;
      q0 = (fa0 + 28'sd512) >>> 10;
      q1 = (fa1 + 28'sd512) >>> 10;
      q2 = (fa2 + 28'sd512) >>> 10;
      fin_ok = !q0[27] && (q0 <= $signed({14'd0, AngMax})) &&
               !q1[27] && (q1 <= $signed({14'd0, AngMax})) &&
               !q2[27] && (q2 <= $signed({14'd0, AngMax}));
   end

   // operand launch for the unit owned by the current state
   always_comb begin
      mul_go  = 1'b0;
      mul_opa = '0;
      mul_opb = '0;
      sq_go   = 1'b0;
      sq_opv  = '0;
      cor_go  = 1'b0;
      cor_opx = '0;
      cor_opy = '0;
      if (!ph_ff) begin
         case (st_ff)
            E_SQX: begin
               mul_go  = 1'b1;
               mul_opa = 64'(mag18(18'(ex_ff)));
               mul_opb = 32'(mag18(18'(ex_ff)));
            end
            E_SQY: begin
               mul_go  = 1'b1;
               mul_opa = 64'(mag18(18'(ey_ff)));
               mul_opb = 32'(mag18(18'(ey_ff)));
            end
            E_RT: begin
               sq_go  = 1'b1;
               sq_opv = t0_ff;
            end
            E_SQV: begin
               mul_go  = 1'b1;
               mul_opa = 64'(mag18(vv_ff));
               mul_opb = 32'(mag18(vv_ff));
            end
            E_SQZ: begin
               mul_go  = 1'b1;
               mul_opa = 64'(mag18(18'(ez_ff)));
               mul_opb = 32'(mag18(18'(ez_ff)));
            end
            E_SQD: begin
               sq_go  = 1'b1;
               sq_opv = 64'({dsum_ff, 16'd0});
            end
            E_FF: begin
               mul_go  = 1'b1;
               mul_opa = 64'(femur_len);
               mul_opb = 32'(femur_len);
            end
            E_TT: begin
               mul_go  = 1'b1;
               mul_opa = 64'(tibia_len);
               mul_opb = 32'(tibia_len);
            end
            E_D1: begin
               mul_go  = 1'b1;
               mul_opa = 64'(ss_ff);
               mul_opb = 32'({femur_len, 1'b0});
            end
            E_ADD: begin
               mul_go  = 1'b1;
               mul_opa = 64'(ac_d_ff[29:0]);
               mul_opb = 32'(ac_d_ff[29:0]);
            end
            E_AMM: begin
               mul_go  = 1'b1;
               mul_opa = 64'(ac_m_ff[29:0]);
               mul_opb = 32'(ac_m_ff[29:0]);
            end
            E_ASQ: begin
               sq_go  = 1'b1;
               sq_opv = t0_ff;
            end
            E_ACOR: begin
               cor_go  = 1'b1;
               cor_opy = $signed({2'b00, t0_ff[30:0]});
               cor_opx = ac_neg_ff ? -$signed({3'b000, ac_m_ff[29:0]})
                                   : $signed({3'b000, ac_m_ff[29:0]});
            end
            E_D2: begin
               mul_go  = 1'b1;
               mul_opa = 64'(tibia_len);
               mul_opb = 32'({femur_len, 1'b0});
            end
            E_BASE: begin
               cor_go = 1'b1;
               if (ex_ff[15]) begin
                  cor_opy = -$signed({{17{ey_ff[15]}}, ey_ff});
                  cor_opx = -$signed({{17{ex_ff[15]}}, ex_ff});
               end else begin
                  cor_opy = $signed({{17{ey_ff[15]}}, ey_ff});
                  cor_opx = $signed({{17{ex_ff[15]}}, ex_ff});
               end
            end
            E_MID: begin
               cor_go  = 1'b1;
               cor_opy = $signed({{17{ez_ff[15]}}, ez_ff});
               cor_opx = $signed({{15{vv_ff[17]}}, vv_ff});
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      case (st_ff)
         E_SQX:   st_nxt = E_SQY;
         E_SQY:   st_nxt = E_RT;
         E_RT:    st_nxt = E_SQV;
         E_SQV:   st_nxt = E_SQZ;
         E_SQZ:   st_nxt = E_SQD;
         E_SQD:   st_nxt = E_FF;
         E_FF:    st_nxt = E_TT;
         E_TT:    st_nxt = E_D1;
         E_D1:    st_nxt = E_ACHK;
         E_ADD:   st_nxt = E_AMM;
         E_AMM:   st_nxt = E_ASQ;
         E_ASQ:   st_nxt = E_ACOR;
         E_ACOR:  st_nxt = ac_sel_ff ? E_BASE : E_D2;
         E_D2:    st_nxt = E_ACHK;
         E_BASE:  st_nxt = E_MID;
         E_MID:   st_nxt = E_FIN;
         default: st_nxt = E_IDLE;
      endcase
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= E_IDLE;
         ph_ff   <= 1'b0;
         stat_ff <= '0;
      end else begin
         stat_ff.done <= 1'b0;
         case (st_ff)
            E_IDLE: begin
               ph_ff <= 1'b0;
               if (start) st_ff <= E_SQX;
            end
            E_ACHK: st_ff <= ac_bad ? E_FIN : E_ASHF;
            E_ASHF: if (!(|ac_d_ff[43:30])) st_ff <= E_ADD;
            E_FIN: begin
               stat_ff.done <= 1'b1;
               stat_ff.ok   <= fin_ok && !fail_ff;
               st_ff        <= E_IDLE;
            end
            default: begin
               if (!ph_ff) begin
                  ph_ff <= 1'b1;
               end else if (!unit_busy) begin
                  ph_ff <= 1'b0;
                  st_ff <= st_nxt;
               end
            end
         endcase
      end
   end

   // datapath captures
   always_ff @(posedge clock) begin
      case (st_ff)
         E_IDLE: if (start) begin
            ex_ff   <= x_in;
            ey_ff   <= y_in;
            ez_ff   <= z_in;
            fail_ff <= 1'b0;
         end
         E_SQX: if (cap) t0_ff <= mul_acc_ff;
         E_SQY: if (cap) t0_ff <= t0_ff + mul_acc_ff;
         E_RT:  if (cap) vv_ff <= vv_in;
         E_SQV: if (cap) t0_ff <= mul_acc_ff;
         E_SQZ: if (cap) dsum_ff <= 34'(t0_ff + mul_acc_ff);
         E_SQD: if (cap) ss_ff <= sq_r_ff[24:0];
         E_FF:  if (cap) fsq_ff <= mul_acc_ff[27:0];
         E_TT:  if (cap) tsq_ff <= mul_acc_ff[27:0];
         E_D1: if (cap) begin
            ac_d_ff   <= mul_acc_ff[43:0];
            ac_m_ff   <= n1_mag;
            ac_neg_ff <= n1_in[44];
            ac_sel_ff <= 1'b0;
         end
         E_ACHK: if (ac_bad) fail_ff <= 1'b1;
         // bring both terms of the ratio below 2^30 one bit at a time, keeping the ratio
         E_ASHF: if (|ac_d_ff[43:30]) begin
            ac_d_ff <= ac_d_ff >> 1;
            ac_m_ff <= ac_m_ff >> 1;
         end
         E_ADD: if (cap) t0_ff <= mul_acc_ff;
         E_AMM: if (cap) t0_ff <= t0_ff - mul_acc_ff;
         E_ASQ: if (cap) t0_ff <= sq_r_ff;
         E_ACOR: if (cap) begin
            if (ac_sel_ff) kn_ff <= cor_ang_ff;
            else           sh_ff <= cor_ang_ff;
         end
         E_D2: if (cap) begin
            ac_d_ff   <= mul_acc_ff[43:0];
            ac_m_ff   <= n2_mag;
            ac_neg_ff <= n2_in[44];
            ac_sel_ff <= 1'b1;
         end
         E_BASE: if (cap) ab_ff <= cor_ang_ff;
         E_MID:  if (cap) az_ff <= cor_ang_ff;
         E_FIN: begin
            ab_out_ff <= q0[AngW-1:0];
            am_out_ff <= q1[AngW-1:0];
            at_out_ff <= q2[AngW-1:0];
         end
         default: ;
      endcase
   end

   // multiplier
   always_ff @(posedge clock) begin
      if (reset) begin
         mul_busy_ff <= 1'b0;
      end else if (mul_go) begin
         mul_busy_ff <= 1'b1;
      end else if (mul_busy_ff && mul_b_ff == '0) begin
         mul_busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (mul_go) begin
         mul_a_ff   <= mul_opa;
         mul_b_ff   <= mul_opb;
         mul_acc_ff <= '0;
      end else if (mul_busy_ff && mul_b_ff != '0) begin
         if (mul_b_ff[0]) mul_acc_ff <= mul_acc_ff + mul_a_ff;
         mul_a_ff <= mul_a_ff << 1;
         mul_b_ff <= mul_b_ff >> 1;
      end
   end

   // square root
   always_ff @(posedge clock) begin
      if (reset) begin
         sq_busy_ff <= 1'b0;
      end else if (sq_go) begin
         sq_busy_ff <= 1'b1;
      end else if (sq_busy_ff && sq_b_ff == '0) begin
         sq_busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (sq_go) begin
         sq_v_ff <= sq_opv;
         sq_r_ff <= '0;
         sq_b_ff <= 64'h4000_0000_0000_0000;
      end else if (sq_busy_ff && sq_b_ff != '0) begin
         if (sq_v_ff >= sq_trial) begin
            sq_v_ff <= sq_v_ff - sq_trial;
            sq_r_ff <= (sq_r_ff >> 1) + sq_b_ff;
         end else begin
            sq_r_ff <= sq_r_ff >> 1;
         end
         sq_b_ff <= sq_b_ff >> 2;
      end
   end

   // cordic
   assign cor_x0 = {{3{cor_opx[32]}}, cor_opx, 16'd0};
   assign cor_y0 = {{3{cor_opy[32]}}, cor_opy, 16'd0};

   always_ff @(posedge clock) begin
      if (reset) begin
         cor_busy_ff <= 1'b0;
      end else if (cor_go) begin
         // both inputs zero gives angle zero at once
         cor_busy_ff <= (cor_opx != '0) || (cor_opy != '0);
      end else if (cor_busy_ff && cor_i_ff == CordIdxW'(CORDIC_STEPS)) begin
         cor_busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cor_go) begin
         cor_i_ff <= '0;
         if (cor_x0[CordW-1]) begin
            // quadrant pre-rotation by 90 degrees
            if (!cor_y0[CordW-1]) begin
               cor_x_ff   <= cor_y0;
               cor_y_ff   <= -cor_x0;
               cor_ang_ff <= Deg90;
            end else begin
               cor_x_ff   <= -cor_y0;
               cor_y_ff   <= cor_x0;
               cor_ang_ff <= -Deg90;
            end
         end else begin
            cor_x_ff   <= cor_x0;
            cor_y_ff   <= cor_y0;
            cor_ang_ff <= '0;
         end
      end else if (cor_busy_ff && cor_i_ff != CordIdxW'(CORDIC_STEPS)) begin
         if (cor_y_ff > 0) begin
            cor_x_ff   <= cor_x_ff + (cor_y_ff >>> cor_i_ff);
            cor_y_ff   <= cor_y_ff - (cor_x_ff >>> cor_i_ff);
            cor_ang_ff <= cor_ang_ff + atan_step(cor_i_ff);
         end else begin
            cor_x_ff   <= cor_x_ff - (cor_y_ff >>> cor_i_ff);
            cor_y_ff   <= cor_y_ff + (cor_x_ff >>> cor_i_ff);
            cor_ang_ff <= cor_ang_ff - atan_step(cor_i_ff);
         end
         cor_i_ff <= cor_i_ff + 1'b1;
      end
   end

   assign stat     = stat_ff;
   assign ang_base = ab_out_ff;
   assign ang_mid  = am_out_ff;
   assign ang_tip  = at_out_ff;

endmodule

// ----- src/leg_inverse_kinematics_mover_top.sv -----
// leg_inverse_kinematics_mover_top: request handling, step midpoint, joint and position state,
// configuration registers. depends on lik_pkg, lik_req_if, lik_rsp_if and lik_engine.
`timescale 1ns / 1ps
//
// usage
// - req_bus takes one transaction per request: req_type 0 moves straight to the target,
//   req_type 1 steps through a lifted midpoint and emits two moves of half the duration.
// - rsp_bus carries one move per transaction: held start angles, end angles, span, a
//   last_of_run mark and a fault flag; a fault ends the request and keeps the state.
// - csr_we/csr_index/csr_wdata write the segment lengths and step lift, idle time only.
// - one request is worked at a time; req_bus.ready is high only while idle.
// - each move's time is set by the bit-serial multiplier (one multiplier bit per cycle,
//   twelve products) and the square-root unit (four roots), plus four cordic runs of
//   CORDIC_STEPS micro-rotations each; a step runs the engine twice.
// - the result sits in an output register until rsp_bus.ready; a stalled receiver holds
//   the block, and the second move of a step starts once the first is taken.
// - synchronous reset clears joints and position to zero and loads the default lengths
//   (400, 1200, 1600, lift 320).
//

module leg_inverse_kinematics_mover_top import lik_pkg::*; #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic            clock,
   input  logic            reset,
   lik_req_if.sink         req_bus,
   lik_rsp_if.source       rsp_bus,
   input  logic            csr_we,
   input  logic [1:0]      csr_index,
   input  logic [LenW-1:0] csr_wdata
);

   localparam logic [1:0] T_IDLE = 2'd0;
   localparam logic [1:0] T_RUN  = 2'd1;
   localparam logic [1:0] T_OUT  = 2'd2;

   logic [1:0] st_ff;
   logic [LenW-1:0] hip_ff, femur_ff, tibia_ff, lift_ff;
   logic signed [CoordW-1:0] pos_x_ff, pos_y_ff, pos_z_ff;
   angle_type jb_ff, jm_ff, jt_ff;
   logic signed [CoordW-1:0] tx_ff, ty_ff, tz_ff;
   logic signed [CoordW-1:0] gx_ff, gy_ff, gz_ff;
   logic [TimeW-1:0] span_ff;
   logic             two_ff, last_ff, go_ff;

   logic             rsp_valid_ff;
   angle_type        o_sb_ff, o_sm_ff, o_st_ff, o_eb_ff, o_em_ff, o_et_ff;
   logic [TimeW-1:0] o_span_ff;
   logic             o_last_ff, o_fault_ff;

   lik_stat_type eng_stat;
   angle_type    eng_b, eng_m, eng_t;

   logic req_accept;
   logic signed [CoordW:0]   sum_x, sum_y, sum_z;
   logic signed [CoordW+1:0] mz_wide;
   logic signed [CoordW-1:0] mid_x, mid_y, mid_z;

   assign req_accept = req_bus.valid && req_bus.ready;

   // step midpoint: floor of the average, lift added to z with saturation
   always_comb begin
      sum_x   = $signed({req_bus.target_x[15], req_bus.target_x}) +
                $signed({pos_x_ff[15], pos_x_ff});
      sum_y   = $signed({req_bus.target_y[15], req_bus.target_y}) +
                $signed({pos_y_ff[15], pos_y_ff});
      sum_z   = $signed({req_bus.target_z[15], req_bus.target_z}) +
                $signed({pos_z_ff[15], pos_z_ff});
      mid_x   = sum_x[CoordW:1];
      mid_y   = sum_y[CoordW:1];
      mz_wide = $signed({{2{sum_z[CoordW]}}, sum_z[CoordW:1]}) + $signed({4'b0000, lift_ff});
      mid_z   = (mz_wide > 18'sd32767) ? 16'sh7fff : mz_wide[CoordW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hip_ff   <= 14'd400;
         femur_ff <= 14'd1200;
         tibia_ff <= 14'd1600;
         lift_ff  <= 14'd320;
      end else if (csr_we) begin
         case (csr_index)
            CSR_HIP_OFFSET: hip_ff   <= csr_wdata;
            CSR_FEMUR:      femur_ff <= csr_wdata;
            CSR_TIBIA:      tibia_ff <= csr_wdata;
            CSR_STEP_LIFT:  lift_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= T_IDLE;
         go_ff        <= 1'b0;
         two_ff       <= 1'b0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         pos_z_ff     <= '0;
         jb_ff        <= '0;
         jm_ff        <= '0;
         jt_ff        <= '0;
      end else begin
         go_ff <= 1'b0;
         case (st_ff)
            T_IDLE: if (req_accept) begin
               go_ff <= 1'b1;
               st_ff <= T_RUN;
               if (req_bus.req_type) begin
                  two_ff  <= 1'b1;
                  last_ff <= 1'b0;
               end else begin
                  two_ff  <= 1'b0;
                  last_ff <= 1'b1;
               end
            end
            T_RUN: if (eng_stat.done) begin
               rsp_valid_ff <= 1'b1;
               st_ff        <= T_OUT;
               if (eng_stat.ok) begin
                  jb_ff    <= eng_b;
                  jm_ff    <= eng_m;
                  jt_ff    <= eng_t;
                  pos_x_ff <= gx_ff;
                  pos_y_ff <= gy_ff;
                  pos_z_ff <= gz_ff;
               end else begin
                  two_ff <= 1'b0;
               end
            end
            T_OUT: if (rsp_bus.ready) begin
               rsp_valid_ff <= 1'b0;
               if (two_ff) begin
                  // second half of a step: go on to the real target
                  two_ff  <= 1'b0;
                  last_ff <= 1'b1;
                  go_ff   <= 1'b1;
                  st_ff   <= T_RUN;
               end else begin
                  st_ff <= T_IDLE;
               end
            end
            default: st_ff <= T_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (st_ff == T_IDLE && req_accept) begin
         tx_ff <= req_bus.target_x;
         ty_ff <= req_bus.target_y;
         tz_ff <= req_bus.target_z;
         if (req_bus.req_type) begin
            gx_ff   <= mid_x;
            gy_ff   <= mid_y;
            gz_ff   <= mid_z;
            span_ff <= req_bus.move_time >> 1;
         end else begin
            gx_ff   <= req_bus.target_x;
            gy_ff   <= req_bus.target_y;
            gz_ff   <= req_bus.target_z;
            span_ff <= req_bus.move_time;
         end
      end else if (st_ff == T_OUT && rsp_bus.ready && two_ff) begin
         gx_ff <= tx_ff;
         gy_ff <= ty_ff;
         gz_ff <= tz_ff;
      end
      if (st_ff == T_RUN && eng_stat.done) begin
         o_sb_ff <= jb_ff;
         o_sm_ff <= jm_ff;
         o_st_ff <= jt_ff;
         if (eng_stat.ok) begin
            o_eb_ff    <= eng_b;
            o_em_ff    <= eng_m;
            o_et_ff    <= eng_t;
            o_span_ff  <= span_ff;
            o_last_ff  <= last_ff;
            o_fault_ff <= 1'b0;
         end else begin
            o_eb_ff    <= jb_ff;
            o_em_ff    <= jm_ff;
            o_et_ff    <= jt_ff;
            o_span_ff  <= '0;
            o_last_ff  <= 1'b1;
            o_fault_ff <= 1'b1;
         end
      end
   end

   lik_engine #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .start     (go_ff),
      .x_in      (gx_ff),
      .y_in      (gy_ff),
      .z_in      (gz_ff),
      .hip_len   (hip_ff),
      .femur_len (femur_ff),
      .tibia_len (tibia_ff),
      .stat      (eng_stat),
      .ang_base  (eng_b),
      .ang_mid   (eng_m),
      .ang_tip   (eng_t)
   );

   assign req_bus.ready            = (st_ff == T_IDLE);
   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.start_angle_base = o_sb_ff;
   assign rsp_bus.start_angle_mid  = o_sm_ff;
   assign rsp_bus.start_angle_tip  = o_st_ff;
   assign rsp_bus.end_angle_base   = o_eb_ff;
   assign rsp_bus.end_angle_mid    = o_em_ff;
   assign rsp_bus.end_angle_tip    = o_et_ff;
   assign rsp_bus.move_span        = o_span_ff;
   assign rsp_bus.last_of_run      = o_last_ff;
   assign rsp_bus.fault            = o_fault_ff;

endmodule

// ----- src/lik_checker.sv -----
// lik_checker: port-level assertions for the leg inverse kinematics mover, bound to the top.
// depends on lik_pkg and leg_inverse_kinematics_mover_top.
`timescale 1ns / 1ps

module lik_checker import lik_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [AngW-1:0]  start_angle_base,
   input logic [AngW-1:0]  start_angle_mid,
   input logic [AngW-1:0]  start_angle_tip,
   input logic [AngW-1:0]  end_angle_base,
   input logic [AngW-1:0]  end_angle_mid,
   input logic [AngW-1:0]  end_angle_tip,
   input logic [TimeW-1:0] move_span,
   input logic             last_of_run,
   input logic             fault
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(end_angle_base) &&
      $stable(end_angle_mid) && $stable(end_angle_tip) && $stable(move_span))
      else $error("stalled transaction changed");

   a_fault_move: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && fault |-> last_of_run && move_span == '0 &&
      end_angle_base == start_angle_base && end_angle_mid == start_angle_mid &&
      end_angle_tip == start_angle_tip)
      else $error("fault transaction is not a null final move");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while a result is pending");

   a_second_move: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !last_of_run |=> !rsp_valid && !req_ready)
      else $error("step midpoint not followed by its final move");

endmodule

bind leg_inverse_kinematics_mover_top lik_checker u_lik_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_bus.ready),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .start_angle_base (rsp_bus.start_angle_base),
   .start_angle_mid  (rsp_bus.start_angle_mid),
   .start_angle_tip  (rsp_bus.start_angle_tip),
   .end_angle_base   (rsp_bus.end_angle_base),
   .end_angle_mid    (rsp_bus.end_angle_mid),
   .end_angle_tip    (rsp_bus.end_angle_tip),
   .move_span        (rsp_bus.move_span),
   .last_of_run      (rsp_bus.last_of_run),
   .fault            (rsp_bus.fault)
);
